/* src/assert_macros.svh */
// Assertion macros used by the lexer RTL.
// Holds only macro definitions inside an include guard.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CLX_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define CLX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/clx_pkg.sv */
// Package for the C subset lexer: kinds, codes, mode and state encodings, lookup tables and classifiers.
// Used by c_subset_lexer_core; depends on nothing.
package clx_pkg;

    localparam int CLX_MAX_TOKEN_LEN = 32;

    // Token kinds.
    localparam logic [5:0] KIND_IDENT    = 6'd0;
    localparam logic [5:0] KIND_INT      = 6'd11;
    localparam logic [5:0] KIND_FLOAT    = 6'd12;
    localparam logic [5:0] KIND_OP_BASE  = 6'd13;
    localparam logic [5:0] KIND_OP2_BASE = 6'd31;

    // Error codes.
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_INVALID = 2'd1;
    localparam logic [1:0] ERR_LONE_OP = 2'd2;

    localparam int NUM_KW = 10;

    // Lexer mode, one-hot.
    typedef enum logic [4:0] {
        MODE_EMPTY = 5'b00001,
        MODE_IDENT = 5'b00010,
        MODE_INT   = 5'b00100,
        MODE_FLOAT = 5'b01000,
        MODE_OP    = 5'b10000
    } t_mode;

    // Sequencer state, one-hot.
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_SEND = 4'b0100,
        S_ERR  = 4'b1000
    } t_state;

    // Keyword text, padded with zero bytes.
    localparam logic [7:0] KW_TEXT [NUM_KW][8] = '{
        '{"c", "o", "n", "s", "t", 8'h00, 8'h00, 8'h00},
        '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"f", "l", "o", "a", "t", 8'h00, 8'h00, 8'h00},
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00},
        '{"c", "o", "n", "t", "i", "n", "u", "e"},
        '{"b", "r", "e", "a", "k", 8'h00, 8'h00, 8'h00},
        '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00},
        '{"v", "o", "i", "d", 8'h00, 8'h00, 8'h00, 8'h00}
    };
    localparam logic [3:0] KW_LEN [NUM_KW] = '{
        4'd5, 4'd3, 4'd5, 4'd2, 4'd4, 4'd5, 4'd8, 4'd5, 4'd6, 4'd4
    };

    // Single-character operators in kind order.
    localparam logic [7:0] OP1_TEXT [18] = '{
        "+", "-", "*", "/", "%", "<", ">", ":", "=",
        ";", ",", "(", ")", "[", "]", "{", "}", "!"
    };

    // Two-character operators in kind order.
    localparam logic [7:0] OP2_A [6] = '{"<", ">", "=", "!", "&", "|"};
    localparam logic [7:0] OP2_B [6] = '{"=", "=", "=", "=", "&", "|"};

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0" && c <= "9");
    endfunction

    // Kind of a single-character operator, or zero when there is none.
    function automatic logic [5:0] op1_kind(input logic [7:0] c);
        logic [5:0] kind;
        kind = KIND_IDENT;
        for (int i = 0; i < 18; i++) begin
            if (OP1_TEXT[i] == c) begin
                kind = KIND_OP_BASE + 6'(i);
            end
        end
        return kind;
    endfunction

    function automatic logic is_op_char(input logic [7:0] c);
        return (op1_kind(c) != KIND_IDENT) || (c == "&") || (c == "|");
    endfunction

    // Kind of a two-character operator, or zero when the pair is not one.
    function automatic logic [5:0] pair_kind(input logic [7:0] a, input logic [7:0] b);
        logic [5:0] kind;
        kind = KIND_IDENT;
        for (int i = 0; i < 6; i++) begin
            if (OP2_A[i] == a && OP2_B[i] == b) begin
                kind = KIND_OP2_BASE + 6'(i);
            end
        end
        return kind;
    endfunction

endpackage

/* src/c_subset_lexer_core.sv */
// Top level of the C subset lexer: character classifier, token buffer and drain sequencer.
// Depends on clx_pkg and assert_macros.svh.
//
//  channel  direction  handshake          payload
//  input    in         i_valid / o_stall  i_ch
//  output   out        o_valid / i_stall  o_token_kind, o_value_char, o_is_last,
//                                         o_truncated, o_error_code
//
// A character that only extends a token, or is whitespace between tokens, is taken in the idle state.
// A character that ends a token starts a drain: each buffered character is read from the token
// buffer through its registered read port (read state) and is then sent as one word (send state).
// An error word is sent from the error state. Output stalls hold the send and error states.
// Reset (synchronous, active low) returns the lexer to the empty mode; no clearing pass.
`include "assert_macros.svh"

module c_subset_lexer_core
    import clx_pkg::*;
#(
    parameter int MAX_TOKEN_LEN = CLX_MAX_TOKEN_LEN
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_ch,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [5:0] o_token_kind,
    output logic [7:0] o_value_char,
    output logic       o_is_last,
    output logic       o_truncated,
    output logic [1:0] o_error_code
);

    localparam int AW = $clog2(MAX_TOKEN_LEN);
    localparam int LW = $clog2(MAX_TOKEN_LEN + 1);

    // Sequencer and lexer state.
    t_state              r_state, n_state;
    t_mode               r_mode, n_mode;
    logic [LW-1:0]       r_len, n_len;
    logic                r_ovf, n_ovf;
    logic [NUM_KW-1:0]   r_match, n_match;
    logic [7:0]          r_op0, n_op0;
    logic [5:0]          r_op_kind, n_op_kind;
    logic [AW-1:0]       r_idx, n_idx;
    logic                r_pend_start, n_pend_start;
    t_mode               r_pend_mode, n_pend_mode;
    logic [7:0]          r_pend_ch, n_pend_ch;
    logic [1:0]          r_err_code, n_err_code;
    logic [7:0]          r_err_ch, n_err_ch;

    // Output register.
    logic                r_ovalid, n_ovalid;
    logic [5:0]          r_okind, n_okind;
    logic [7:0]          r_ochar, n_ochar;
    logic                r_olast, n_olast;
    logic                r_otrunc, n_otrunc;
    logic [1:0]          r_oerr, n_oerr;

    // Token buffer.
    logic [7:0]          r_mem [MAX_TOKEN_LEN];
    logic [7:0]          r_rd_data;

    // Token write step.
    logic                tok_wr, tok_start;
    logic [7:0]          tok_ch;
    t_mode               tok_mode;
    logic [LW-1:0]       base_len;
    logic [NUM_KW-1:0]   base_match, upd_match;
    logic                w_en;
    logic [AW-1:0]       w_addr;

    // Classification of the incoming character.
    logic c_sp, c_al, c_dg, c_us, c_dot, c_op, c_pair, c_lone;
    logic out_free, send_last;
    logic [5:0] cur_kind, kw_kind;

    assign c_sp  = is_space(i_ch);
    assign c_al  = is_alpha(i_ch);
    assign c_dg  = is_digit(i_ch);
    assign c_us  = (i_ch == "_");
    assign c_dot = (i_ch == ".");
    assign c_op  = is_op_char(i_ch);
    assign c_pair = c_op && (r_len == LW'(1)) && (pair_kind(r_op0, i_ch) != KIND_IDENT);
    assign c_lone = (r_len == LW'(1)) && ((r_op0 == "&") || (r_op0 == "|"));

    assign out_free  = !r_ovalid || !i_stall;
    assign send_last = ((LW'(r_idx) + LW'(1)) == r_len);

    // Keyword lookup from the running per-keyword match flags.
    always_comb begin
        kw_kind = KIND_IDENT;
        for (int k = 0; k < NUM_KW; k++) begin
            if (!r_ovf && r_match[k] && (r_len == LW'(KW_LEN[k]))) begin
                kw_kind = 6'(k + 1);
            end
        end
    end

    // Kind of the buffered token.
    always_comb begin
        unique case (r_mode)
            MODE_IDENT: cur_kind = kw_kind;
            MODE_INT:   cur_kind = KIND_INT;
            MODE_FLOAT: cur_kind = KIND_FLOAT;
            MODE_OP:    cur_kind = r_op_kind;
            default:    cur_kind = KIND_IDENT;
        endcase
    end

    // Base of a write: a fresh token starts at zero with every keyword still possible.
    assign base_len   = tok_start ? '0 : r_len;
    assign base_match = tok_start ? '1 : r_match;

    always_comb begin
        for (int k = 0; k < NUM_KW; k++) begin
            upd_match[k] = base_match[k] && (base_len < LW'(KW_LEN[k])) &&
                           (KW_TEXT[k][base_len[2:0]] == tok_ch);
        end
    end

    assign w_en   = tok_wr && (base_len < LW'(MAX_TOKEN_LEN));
    assign w_addr = base_len[AW-1:0];

    // Sequencer next-state logic.
    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_len        = r_len;
        n_ovf        = r_ovf;
        n_match      = r_match;
        n_op0        = r_op0;
        n_op_kind    = r_op_kind;
        n_idx        = r_idx;
        n_pend_start = r_pend_start;
        n_pend_mode  = r_pend_mode;
        n_pend_ch    = r_pend_ch;
        n_err_code   = r_err_code;
        n_err_ch     = r_err_ch;
        n_ovalid     = r_ovalid && i_stall;
        n_okind      = r_okind;
        n_ochar      = r_ochar;
        n_olast      = r_olast;
        n_otrunc     = r_otrunc;
        n_oerr       = r_oerr;
        tok_wr       = 1'b0;
        tok_start    = 1'b0;
        tok_ch       = i_ch;
        tok_mode     = MODE_EMPTY;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    // Defaults for a character that ends the token: drain it first.
                    n_idx        = '0;
                    n_pend_ch    = i_ch;
                    n_pend_start = 1'b0;
                    n_pend_mode  = MODE_OP;
                    n_err_ch     = i_ch;
                    n_err_code   = ERR_INVALID;
                    unique case (r_mode)
                        MODE_IDENT: begin
                            if (c_al || c_dg || c_us) begin
                                tok_wr = 1'b1;
                            end else if (c_sp) begin
                                n_state = S_READ;
                            end else if (c_op) begin
                                n_state      = S_READ;
                                n_pend_start = 1'b1;
                            end else begin
                                n_state = S_ERR;
                            end
                        end
                        MODE_INT: begin
                            if (c_al || c_dg) begin
                                tok_wr = 1'b1;
                            end else if (c_dot) begin
                                tok_wr = 1'b1;
                                n_mode = MODE_FLOAT;
                            end else if (c_sp) begin
                                n_state = S_READ;
                            end else if (c_op) begin
                                n_state      = S_READ;
                                n_pend_start = 1'b1;
                            end else begin
                                n_state = S_ERR;
                            end
                        end
                        MODE_FLOAT: begin
                            if (c_dg) begin
                                tok_wr = 1'b1;
                            end else if (c_sp) begin
                                n_state = S_READ;
                            end else if (c_op) begin
                                n_state      = S_READ;
                                n_pend_start = 1'b1;
                            end else begin
                                n_state = S_ERR;
                            end
                        end
                        MODE_OP: begin
                            if (!(c_sp || c_al || c_us || c_dg || c_dot || c_op)) begin
                                n_state = S_ERR;
                            end else if (c_pair) begin
                                tok_wr    = 1'b1;
                                n_op_kind = pair_kind(r_op0, i_ch);
                            end else if (c_lone) begin
                                n_state    = S_ERR;
                                n_err_code = ERR_LONE_OP;
                                n_err_ch   = r_op0;
                            end else begin
                                n_state      = S_READ;
                                n_pend_start = !c_sp;
                                if (c_al || c_us) begin
                                    n_pend_mode = MODE_IDENT;
                                end else if (c_dg) begin
                                    n_pend_mode = MODE_INT;
                                end else if (c_dot) begin
                                    n_pend_mode = MODE_FLOAT;
                                end
                            end
                        end
                        default: begin
                            // Empty mode: whitespace is skipped, a token character opens a token.
                            if (c_sp) begin
                                n_len = '0;
                            end else if (c_al || c_us) begin
                                tok_wr = 1'b1; tok_start = 1'b1; tok_mode = MODE_IDENT;
                            end else if (c_dg) begin
                                tok_wr = 1'b1; tok_start = 1'b1; tok_mode = MODE_INT;
                            end else if (c_dot) begin
                                tok_wr = 1'b1; tok_start = 1'b1; tok_mode = MODE_FLOAT;
                            end else if (c_op) begin
                                tok_wr = 1'b1; tok_start = 1'b1; tok_mode = MODE_OP;
                            end else begin
                                n_state = S_ERR;
                            end
                        end
                    endcase
                    // An error drops the pending token.
                    if (n_state == S_ERR) begin
                        n_mode = MODE_EMPTY;
                        n_len  = '0;
                        n_ovf  = 1'b0;
                    end
                end
            end
            S_READ: begin
                n_state = S_SEND;
            end
            S_SEND: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_okind  = cur_kind;
                    n_ochar  = r_rd_data;
                    n_olast  = send_last;
                    n_otrunc = r_ovf;
                    n_oerr   = ERR_NONE;
                    if (send_last) begin
                        n_state = S_IDLE;
                        if (r_pend_start) begin
                            tok_wr    = 1'b1;
                            tok_start = 1'b1;
                            tok_ch    = r_pend_ch;
                            tok_mode  = r_pend_mode;
                        end else begin
                            n_mode = MODE_EMPTY;
                            n_len  = '0;
                            n_ovf  = 1'b0;
                        end
                    end else begin
                        n_idx   = r_idx + AW'(1);
                        n_state = S_READ;
                    end
                end
            end
            S_ERR: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_okind  = KIND_IDENT;
                    n_ochar  = r_err_ch;
                    n_olast  = 1'b1;
                    n_otrunc = 1'b0;
                    n_oerr   = r_err_code;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Append one character to the buffer, or note the overflow.
        if (tok_wr) begin
            if (tok_start) begin
                n_mode    = tok_mode;
                n_ovf     = 1'b0;
                n_op0     = tok_ch;
                n_op_kind = op1_kind(tok_ch);
            end
            if (base_len < LW'(MAX_TOKEN_LEN)) begin
                n_len   = base_len + LW'(1);
                n_match = upd_match;
            end else begin
                n_ovf = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mode   <= MODE_EMPTY;
            r_len    <= '0;
            r_ovf    <= 1'b0;
            r_ovalid <= 1'b0;
            r_idx    <= '0;
        end else begin
            r_state  <= n_state;
            r_mode   <= n_mode;
            r_len    <= n_len;
            r_ovf    <= n_ovf;
            r_ovalid <= n_ovalid;
            r_idx    <= n_idx;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_match      <= n_match;
        r_op0        <= n_op0;
        r_op_kind    <= n_op_kind;
        r_pend_start <= n_pend_start;
        r_pend_mode  <= n_pend_mode;
        r_pend_ch    <= n_pend_ch;
        r_err_code   <= n_err_code;
        r_err_ch     <= n_err_ch;
        r_okind      <= n_okind;
        r_ochar      <= n_ochar;
        r_olast      <= n_olast;
        r_otrunc     <= n_otrunc;
        r_oerr       <= n_oerr;
    end

    // Token buffer: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[w_addr] <= tok_ch;
        end
        r_rd_data <= r_mem[r_idx];
    end

    assign o_stall      = (r_state != S_IDLE);
    assign o_valid      = r_ovalid;
    assign o_token_kind = r_okind;
    assign o_value_char = r_ochar;
    assign o_is_last    = r_olast;
    assign o_truncated  = r_otrunc;
    assign o_error_code = r_oerr;

    // An error word is always a single, last word of kind zero.
    `CLX_ASSERT_NOW(a_err_word, i_clk, i_rst_n, r_ovalid && (r_oerr != ERR_NONE), r_olast && (r_okind == KIND_IDENT) && !r_otrunc, "error word malformed")
    // Overflow is only flagged once the buffer is full.
    `CLX_ASSERT_NOW(a_ovf_full, i_clk, i_rst_n, r_ovf, r_len == LW'(MAX_TOKEN_LEN), "overflow with free buffer space")
    // The drain index stays inside the buffered token.
    `CLX_ASSERT_NOW(a_idx_range, i_clk, i_rst_n, (r_state == S_READ) || (r_state == S_SEND), LW'(r_idx) < r_len, "drain index past token end")
    // Once the last word of a run is sent the sequencer is ready again.
    `CLX_ASSERT_NEXT(a_last_idle, i_clk, i_rst_n, (r_state == S_SEND) && out_free && send_last, r_state == S_IDLE, "sequencer did not return to idle")

endmodule
